FILE: hdl/dse_pkg.sv
// Shared widths, register codes and channel structs for the diffusion stencil unit.
// No dependencies; every other file of the block refers to this package by scoped names.
package dse_pkg;

    localparam int SAMPLE_W   = 32;
    localparam int ROW_W      = 16;
    localparam int COL_OUT_W  = 8;
    localparam int COLS_CFG_W = 9;
    localparam int COEF_W     = 18;
    localparam int NUM_LANES  = 3;
    localparam int PADDR_W    = 4;
    localparam int PDATA_W    = 32;

    // Register indexes (byte address = 4 * index)
    localparam logic [1:0] REG_ROWS     = 2'd0;
    localparam logic [1:0] REG_COLS     = 2'd1;
    localparam logic [1:0] REG_COEF_ROW = 2'd2;
    localparam logic [1:0] REG_COEF_COL = 2'd3;

    localparam logic [ROW_W-1:0]      ROWS_RESET = 16'd64;
    localparam logic [COLS_CFG_W-1:0] COLS_RESET = 9'd256;

    // Result slots one sample can release, in output order
    localparam logic [1:0] LANE_UPPER = 2'd0;  // point one row above the sample
    localparam logic [1:0] LANE_PREV  = 2'd1;  // last row, column to the left
    localparam logic [1:0] LANE_CUR   = 2'd2;  // last row, last column

    typedef struct packed {
        logic [ROW_W-1:0]      rows_in_use;
        logic [COLS_CFG_W-1:0] cols_in_use;
        logic [COEF_W-1:0]     coef_row_dir;
        logic [COEF_W-1:0]     coef_col_dir;
    } cfg_t;

    typedef struct packed {
        logic                       valid;
        logic                       eob;
        logic                       eog;
        logic [ROW_W-1:0]           row;
        logic [COL_OUT_W-1:0]       col;
        logic signed [SAMPLE_W-1:0] ctr;
        logic signed [SAMPLE_W-1:0] up;
        logic signed [SAMPLE_W-1:0] down;
        logic signed [SAMPLE_W-1:0] left;
        logic signed [SAMPLE_W-1:0] right;
    } lane_t;

endpackage

FILE: hdl/dse_sample_if.sv
// Input channel of the diffusion stencil unit: one grid sample per request.
// Depends on dse_pkg for the sample width.
interface dse_sample_if;
    logic                                valid;
    logic                                ready;
    logic signed [dse_pkg::SAMPLE_W-1:0] sample_value;

    modport source (output valid, output sample_value, input ready);
    modport sink   (input valid, input sample_value, output ready);
endinterface

FILE: hdl/dse_result_if.sv
// Output channel of the diffusion stencil unit: one updated grid point per request.
// Depends on dse_pkg for the field widths.
interface dse_result_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [dse_pkg::SAMPLE_W-1:0]  new_value;
    logic [dse_pkg::ROW_W-1:0]            out_row;
    logic [dse_pkg::COL_OUT_W-1:0]        out_col;
    logic                                 end_of_burst;
    logic                                 end_of_grid;

    modport source (output valid, output new_value, output out_row, output out_col,
                    output end_of_burst, output end_of_grid, input ready);
    modport sink   (input valid, input new_value, input out_row, input out_col,
                    input end_of_burst, input end_of_grid, output ready);
endinterface

FILE: hdl/dse_cfg_regs.sv
// APB register file of the diffusion stencil unit: grid size and the two weights.
// Depends on dse_pkg for cfg_t, register codes and reset values.
module dse_cfg_regs (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [dse_pkg::PADDR_W-1:0]  paddr,
    input  logic [dse_pkg::PDATA_W-1:0]  pwdata,
    output logic [dse_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready,
    output dse_pkg::cfg_t                cfg
);

    dse_pkg::cfg_t cfg_reg;
    logic          wr_en;
    logic [1:0]    reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[dse_pkg::PADDR_W-1:2];
    assign cfg     = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.rows_in_use  <= dse_pkg::ROWS_RESET;
            cfg_reg.cols_in_use  <= dse_pkg::COLS_RESET;
            cfg_reg.coef_row_dir <= '0;
            cfg_reg.coef_col_dir <= '0;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                dse_pkg::REG_ROWS:
                    cfg_reg.rows_in_use  <= pwdata[dse_pkg::ROW_W-1:0];
                dse_pkg::REG_COLS:
                    cfg_reg.cols_in_use  <= pwdata[dse_pkg::COLS_CFG_W-1:0];
                dse_pkg::REG_COEF_ROW:
                    cfg_reg.coef_row_dir <= pwdata[dse_pkg::COEF_W-1:0];
                dse_pkg::REG_COEF_COL:
                    cfg_reg.coef_col_dir <= pwdata[dse_pkg::COEF_W-1:0];
                default:
                    cfg_reg <= cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            dse_pkg::REG_ROWS:
                prdata = dse_pkg::PDATA_W'(cfg_reg.rows_in_use);
            dse_pkg::REG_COLS:
                prdata = dse_pkg::PDATA_W'(cfg_reg.cols_in_use);
            dse_pkg::REG_COEF_ROW:
                prdata = dse_pkg::PDATA_W'(cfg_reg.coef_row_dir);
            dse_pkg::REG_COEF_COL:
                prdata = dse_pkg::PDATA_W'(cfg_reg.coef_col_dir);
            default:
                prdata = '0;
        endcase
    end

endmodule

FILE: hdl/dse_line_bank.sv
// One line store of the diffusion stencil unit: one write port, two registered read ports.
// Depends on dse_pkg for the sample width.
module dse_line_bank #(
    parameter int DEPTH  = 256,
    parameter int ADDR_W = 8
) (
    input  logic                          clk,
    input  logic                          wr_en,
    input  logic [ADDR_W-1:0]             wr_addr,
    input  logic [dse_pkg::SAMPLE_W-1:0]  wr_data,
    input  logic                          rd_en,
    input  logic [ADDR_W-1:0]             rd_addr_a,
    input  logic [ADDR_W-1:0]             rd_addr_b,
    output logic [dse_pkg::SAMPLE_W-1:0]  rd_data_a,
    output logic [dse_pkg::SAMPLE_W-1:0]  rd_data_b
);

    logic [dse_pkg::SAMPLE_W-1:0] mem [DEPTH];
    logic [dse_pkg::SAMPLE_W-1:0] rd_a_reg;
    logic [dse_pkg::SAMPLE_W-1:0] rd_b_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_a_reg <= mem[rd_addr_a];
            rd_b_reg <= mem[rd_addr_b];
        end
    end

    assign rd_data_a = rd_a_reg;
    assign rd_data_b = rd_b_reg;

endmodule

FILE: hdl/dse_result_stage.sv
// Product register, rounding/saturation and output register of the diffusion stencil unit.
// Depends on dse_pkg (lane_t, widths) and dse_result_if; drains up to three results per load.
module dse_result_stage (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic                                        lanes_valid,
    input  dse_pkg::lane_t [dse_pkg::NUM_LANES-1:0]     lanes,
    input  logic [dse_pkg::COEF_W-1:0]                  coef_row_dir,
    input  logic [dse_pkg::COEF_W-1:0]                  coef_col_dir,
    output logic                                        advance,
    dse_result_if.source                                results
);

    localparam int DIFF_W    = dse_pkg::SAMPLE_W + 2;
    localparam int PROD_W    = DIFF_W + dse_pkg::COEF_W + 1;
    localparam int SUM_W     = PROD_W + 1;
    localparam int FRAC_BITS = 16;
    localparam int T_W       = SUM_W - FRAC_BITS;
    localparam int V_W       = T_W + 1;
    localparam int SW        = dse_pkg::SAMPLE_W;

    localparam logic signed [SUM_W-1:0] ROUND_HALF = SUM_W'(1) << (FRAC_BITS - 1);
    localparam logic signed [V_W-1:0]   V_MAX = {{(V_W-SW+1){1'b0}}, {(SW-1){1'b1}}};
    localparam logic signed [V_W-1:0]   V_MIN = {{(V_W-SW+1){1'b1}}, {(SW-1){1'b0}}};

    typedef struct packed {
        logic                 eob;
        logic                 eog;
        logic [dse_pkg::ROW_W-1:0]     row;
        logic [dse_pkg::COL_OUT_W-1:0] col;
        logic signed [SW-1:0]          ctr;
        logic signed [PROD_W-1:0]      pv;
        logic signed [PROD_W-1:0]      ph;
    } prod_t;

    function automatic prod_t form_products(dse_pkg::lane_t ln,
                                            logic [dse_pkg::COEF_W-1:0] cr,
                                            logic [dse_pkg::COEF_W-1:0] cc);
        logic signed [DIFF_W-1:0]           up_e;
        logic signed [DIFF_W-1:0]           dn_e;
        logic signed [DIFF_W-1:0]           lf_e;
        logic signed [DIFF_W-1:0]           rt_e;
        logic signed [DIFF_W-1:0]           ct_e;
        logic signed [DIFF_W-1:0]           dv;
        logic signed [DIFF_W-1:0]           dh;
        logic signed [dse_pkg::COEF_W:0]    cr_s;
        logic signed [dse_pkg::COEF_W:0]    cc_s;
        prod_t                              p;
        up_e = {{(DIFF_W-SW){ln.up[SW-1]}},    ln.up};
        dn_e = {{(DIFF_W-SW){ln.down[SW-1]}},  ln.down};
        lf_e = {{(DIFF_W-SW){ln.left[SW-1]}},  ln.left};
        rt_e = {{(DIFF_W-SW){ln.right[SW-1]}}, ln.right};
        ct_e = {{(DIFF_W-SW){ln.ctr[SW-1]}},   ln.ctr};
        dv   = up_e - (ct_e <<< 1) + dn_e;
        dh   = lf_e - (ct_e <<< 1) + rt_e;
        cr_s = {1'b0, cr};
        cc_s = {1'b0, cc};
        p.eob = ln.eob;
        p.eog = ln.eog;
        p.row = ln.row;
        p.col = ln.col;
        p.ctr = ln.ctr;
        p.pv  = dv * cr_s;
        p.ph  = dh * cc_s;
        return p;
    endfunction

    // Sum the products, scale by 2^-16 rounding half up, add the center, saturate
    function automatic logic [SW-1:0] finish(prod_t p);
        logic signed [SUM_W-1:0] sum;
        logic signed [T_W-1:0]   t;
        logic signed [V_W-1:0]   v;
        logic [SW-1:0]           res;
        sum = {p.pv[PROD_W-1], p.pv} + {p.ph[PROD_W-1], p.ph} + ROUND_HALF;
        t   = sum[SUM_W-1:FRAC_BITS];
        v   = {{(V_W-SW){p.ctr[SW-1]}}, p.ctr} + {t[T_W-1], t};
        if (v > V_MAX)
        begin
            res = {1'b0, {(SW-1){1'b1}}};
        end
        else if (v < V_MIN)
        begin
            res = {1'b1, {(SW-1){1'b0}}};
        end
        else
        begin
            res = v[SW-1:0];
        end
        return res;
    endfunction

    prod_t [dse_pkg::NUM_LANES-1:0] s2_reg;
    logic  [dse_pkg::NUM_LANES-1:0] mask_reg;
    logic  [dse_pkg::NUM_LANES-1:0] mask_next;
    logic  [dse_pkg::NUM_LANES-1:0] new_mask;
    logic  [dse_pkg::NUM_LANES-1:0] sel_bit;
    logic  [1:0]                    sel;
    logic                           any_pending;
    logic                           at_most_one;
    logic                           out_free;
    logic                           load;

    logic                           out_valid_reg;
    logic [SW-1:0]                  out_value_reg;
    logic [dse_pkg::ROW_W-1:0]      out_row_reg;
    logic [dse_pkg::COL_OUT_W-1:0]  out_col_reg;
    logic                           out_eob_reg;
    logic                           out_eog_reg;

    assign any_pending = |mask_reg;
    assign at_most_one = (mask_reg & (mask_reg - 1'b1)) == '0;
    assign out_free    = !out_valid_reg || results.ready;
    assign advance     = !any_pending || (out_free && at_most_one);
    assign load        = advance && lanes_valid;

    always_comb
    begin
        for (int i = 0; i < dse_pkg::NUM_LANES; i++)
        begin
            new_mask[i] = lanes[i].valid;
        end
    end

    // lowest pending slot goes first
    always_comb
    begin
        if (mask_reg[dse_pkg::LANE_UPPER])
        begin
            sel = dse_pkg::LANE_UPPER;
        end
        else if (mask_reg[dse_pkg::LANE_PREV])
        begin
            sel = dse_pkg::LANE_PREV;
        end
        else
        begin
            sel = dse_pkg::LANE_CUR;
        end
        sel_bit = dse_pkg::NUM_LANES'(1) << sel;
    end

    always_comb
    begin
        mask_next = mask_reg;
        if (load)
        begin
            mask_next = new_mask;
        end
        else if (out_free && any_pending)
        begin
            mask_next = mask_reg & ~sel_bit;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            mask_reg <= mask_next;
            if (out_free)
            begin
                out_valid_reg <= any_pending;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            for (int i = 0; i < dse_pkg::NUM_LANES; i++)
            begin
                s2_reg[i] <= form_products(lanes[i], coef_row_dir, coef_col_dir);
            end
        end
        if (out_free && any_pending)
        begin
            out_value_reg <= finish(s2_reg[sel]);
            out_row_reg   <= s2_reg[sel].row;
            out_col_reg   <= s2_reg[sel].col;
            out_eob_reg   <= s2_reg[sel].eob;
            out_eog_reg   <= s2_reg[sel].eog;
        end
    end

    assign results.valid        = out_valid_reg;
    assign results.new_value    = out_value_reg;
    assign results.out_row      = out_row_reg;
    assign results.out_col      = out_col_reg;
    assign results.end_of_burst = out_eob_reg;
    assign results.end_of_grid  = out_eog_reg;

    // a pending result with room downstream must show up at the output next cycle
    a_drain_moves: assert property (@(posedge clk) disable iff (!rst_n)
        (any_pending && out_free) |=> out_valid_reg)
        else $error("pending result not moved to the output register");

    // the grid's final point always closes its burst
    a_grid_end_closes_burst: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_eog_reg) |-> out_eob_reg)
        else $error("end_of_grid without end_of_burst");

endmodule

FILE: hdl/diffusion_stencil_euler_step_unit.sv
// Top level of the explicit Euler diffusion step (5-point Laplacian) over a raster grid.
// Depends on dse_pkg, dse_sample_if, dse_result_if, dse_cfg_regs, dse_line_bank,
// dse_result_stage.
//
//  channel   | direction | handshake       | payload
//  ----------+-----------+-----------------+--------------------------------------------
//  samples   | in        | valid / ready   | sample_value (Q16.16)
//  results   | out       | valid / ready   | new_value, out_row, out_col, end_of_burst,
//            |           |                 | end_of_grid
//  APB       | in / out  | psel & penable  | paddr, pwdata, prdata (regs at 4*index)
//
// Rate: one request per clock in every row but the last, while the output is not stalled.
//   In the last row the first request releases one result, the others two and the final one
//   three; the single output register drains one result a clock, so there a new request is
//   taken only once at most one result of the previous request is still waiting.
// Path: an accepted request moves through the sample register and the product register;
//   its results then leave through the output register.
// Reset: rst_n clears counters, line-store rotation, valid flags and the configuration
//   registers; the line stores themselves are not cleared and need no clearing pass.
// Stalls: a stalled output holds its register; the product stage and sample register keep
//   accepting until both are occupied, then samples.ready drops.
module diffusion_stencil_euler_step_unit #(
    parameter int MAX_COLS = 256
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [dse_pkg::PADDR_W-1:0]  paddr,
    input  logic [dse_pkg::PDATA_W-1:0]  pwdata,
    output logic [dse_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready,
    dse_sample_if.sink                   samples,
    dse_result_if.source                 results
);

    localparam int CW  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int EW  = (CW + 1 > dse_pkg::COLS_CFG_W) ? CW + 1 : dse_pkg::COLS_CFG_W;
    localparam int RW  = dse_pkg::ROW_W;
    localparam int SW  = dse_pkg::SAMPLE_W;
    localparam int NB  = 3;
    localparam logic [1:0] BANK_LAST = 2'd2;

    // Rotate the three line stores: current -> middle -> older -> current
    function automatic logic [1:0] bank_inc(logic [1:0] b);
        logic [1:0] r;
        unique case (b)
            2'd0:    r = 2'd1;
            2'd1:    r = 2'd2;
            default: r = 2'd0;
        endcase
        return r;
    endfunction

    function automatic logic [1:0] bank_dec(logic [1:0] b);
        logic [1:0] r;
        unique case (b)
            2'd1:    r = 2'd0;
            2'd2:    r = 2'd1;
            default: r = 2'd2;
        endcase
        return r;
    endfunction

    dse_pkg::cfg_t cfg;

    dse_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // ------------------------------------------------------------------
    // Raster position and frame geometry
    // ------------------------------------------------------------------
    logic [RW-1:0]  row_cnt_reg;
    logic [RW-1:0]  row_cnt_next;
    logic [CW-1:0]  col_cnt_reg;
    logic [CW-1:0]  col_cnt_next;
    logic [1:0]     cur_bank_reg;
    logic [1:0]     cur_bank_next;
    logic [1:0]     mid_bank;
    logic [1:0]     old_bank;
    logic [RW-1:0]  rows_eff;
    logic [EW-1:0]  cols_ext;
    logic [EW-1:0]  cols_eff;
    logic           last_row;
    logic           last_col;
    logic           past_last;
    logic [CW-1:0]  col_ahead;
    logic [CW-1:0]  col_right;
    logic           in_acc;
    logic           advance;

    logic           s1_valid_reg;

    assign in_acc        = samples.valid && samples.ready;
    assign samples.ready = !s1_valid_reg || advance;

    // fewer than two rows or columns act as two; columns clip at the store depth
    assign rows_eff = (cfg.rows_in_use < RW'(2)) ? RW'(2) : cfg.rows_in_use;
    assign cols_ext = EW'(cfg.cols_in_use);
    assign cols_eff = (cols_ext < EW'(2)) ? EW'(2) :
                      ((cols_ext > EW'(MAX_COLS)) ? EW'(MAX_COLS) : cols_ext);

    // a counter at or past the last index counts as the last one
    assign last_row  = row_cnt_reg >= (rows_eff - RW'(1));
    assign last_col  = EW'(col_cnt_reg) >= (cols_eff - EW'(1));
    assign past_last = EW'(col_cnt_reg) > (cols_eff - EW'(1));

    assign mid_bank = bank_dec(cur_bank_reg);
    assign old_bank = bank_inc(cur_bank_reg);

    // right-hand neighbor address; wraps only when it is never used
    assign col_ahead = (col_cnt_reg == CW'(MAX_COLS - 1)) ? '0 : col_cnt_reg + CW'(1);

    // at the last column the right edge reflects onto the second-to-last column
    assign col_right = last_col ? CW'(cols_eff - EW'(2)) : col_ahead;

    always_comb
    begin
        row_cnt_next  = row_cnt_reg;
        col_cnt_next  = col_cnt_reg;
        cur_bank_next = cur_bank_reg;
        if (in_acc)
        begin
            if (last_col)
            begin
                col_cnt_next  = '0;
                row_cnt_next  = last_row ? '0 : row_cnt_reg + RW'(1);
                cur_bank_next = bank_inc(cur_bank_reg);
            end
            else
            begin
                col_cnt_next = col_cnt_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_cnt_reg  <= '0;
            col_cnt_reg  <= '0;
            cur_bank_reg <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            row_cnt_reg  <= row_cnt_next;
            col_cnt_reg  <= col_cnt_next;
            cur_bank_reg <= cur_bank_next;
            if (in_acc)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Line stores: write the current row, read every store at c and at the
    // right-hand neighbor, all on the accepting edge
    // ------------------------------------------------------------------
    logic [SW-1:0] bank_rd_a [NB];
    logic [SW-1:0] bank_rd_b [NB];

    for (genvar b = 0; b < NB; b++)
    begin : g_bank
        dse_line_bank #(
            .DEPTH  (MAX_COLS),
            .ADDR_W (CW)
        ) u_bank (
            .clk       (clk),
            .wr_en     (in_acc && (cur_bank_reg == 2'(b))),
            .wr_addr   (col_cnt_reg),
            .wr_data   (samples.sample_value),
            .rd_en     (in_acc),
            .rd_addr_a (col_cnt_reg),
            .rd_addr_b (col_right),
            .rd_data_a (bank_rd_a[b]),
            .rd_data_b (bank_rd_b[b])
        );
    end

    // ------------------------------------------------------------------
    // Sample register and the history of the previous two samples
    // ------------------------------------------------------------------
    logic signed [SW-1:0] s1_x_reg;
    logic [RW-1:0]        s1_row_reg;
    logic [CW-1:0]        s1_col_reg;
    logic                 s1_last_row_reg;
    logic                 s1_last_col_reg;
    logic                 s1_past_last_reg;
    logic                 s1_has_upper_reg;
    logic                 s1_row_one_reg;
    logic [1:0]           s1_cur_sel_reg;
    logic [1:0]           s1_mid_sel_reg;
    logic [1:0]           s1_old_sel_reg;
    logic signed [SW-1:0] hist_mid_reg;   // middle row, column c-1
    logic signed [SW-1:0] hist_x1_reg;    // current row, column c-1
    logic signed [SW-1:0] hist_x2_reg;    // current row, column c-2

    logic signed [SW-1:0] s1_mid_a;
    logic signed [SW-1:0] s1_mid_b;
    logic signed [SW-1:0] s1_old;
    logic signed [SW-1:0] s1_cur_b;

    assign s1_mid_a = bank_rd_a[s1_mid_sel_reg];
    assign s1_mid_b = bank_rd_b[s1_mid_sel_reg];
    assign s1_old   = bank_rd_a[s1_old_sel_reg];
    assign s1_cur_b = bank_rd_b[s1_cur_sel_reg];

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            s1_x_reg         <= samples.sample_value;
            s1_row_reg       <= row_cnt_reg;
            s1_col_reg       <= col_cnt_reg;
            s1_last_row_reg  <= last_row;
            s1_last_col_reg  <= last_col;
            s1_past_last_reg <= past_last;
            s1_has_upper_reg <= (row_cnt_reg != '0);
            s1_row_one_reg   <= (row_cnt_reg == RW'(1));
            s1_cur_sel_reg   <= cur_bank_reg;
            s1_mid_sel_reg   <= mid_bank;
            s1_old_sel_reg   <= old_bank;
            // shift the window: the outgoing sample becomes column c-1
            hist_mid_reg     <= s1_mid_a;
            hist_x1_reg      <= s1_x_reg;
            hist_x2_reg      <= hist_x1_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stencil operands for the up to three results this sample releases
    // ------------------------------------------------------------------
    dse_pkg::lane_t [dse_pkg::NUM_LANES-1:0] lanes;
    logic                                    col_zero;
    logic                                    col_one;

    assign col_zero = (s1_col_reg == '0);
    assign col_one  = (s1_col_reg == CW'(1));

    always_comb
    begin
        // Row above: center from the middle row, down is this sample.
        // Second row has no older row; reflect it to the sample itself.
        lanes[dse_pkg::LANE_UPPER].valid = s1_has_upper_reg;
        lanes[dse_pkg::LANE_UPPER].row   = s1_row_reg - RW'(1);
        lanes[dse_pkg::LANE_UPPER].col   = dse_pkg::COL_OUT_W'(s1_col_reg);
        lanes[dse_pkg::LANE_UPPER].ctr   = s1_mid_a;
        lanes[dse_pkg::LANE_UPPER].up    = s1_row_one_reg ? s1_x_reg : s1_old;
        lanes[dse_pkg::LANE_UPPER].down  = s1_x_reg;
        lanes[dse_pkg::LANE_UPPER].left  = col_zero ? s1_mid_b : hist_mid_reg;
        lanes[dse_pkg::LANE_UPPER].right = s1_mid_b;

        // Last row, previous column: both vertical neighbors reflect to the middle row.
        // Past a lowered column limit its right edge reflects as well.
        lanes[dse_pkg::LANE_PREV].valid  = s1_last_row_reg && !col_zero;
        lanes[dse_pkg::LANE_PREV].row    = s1_row_reg;
        lanes[dse_pkg::LANE_PREV].col    = dse_pkg::COL_OUT_W'(s1_col_reg - CW'(1));
        lanes[dse_pkg::LANE_PREV].ctr    = hist_x1_reg;
        lanes[dse_pkg::LANE_PREV].up     = hist_mid_reg;
        lanes[dse_pkg::LANE_PREV].down   = hist_mid_reg;
        lanes[dse_pkg::LANE_PREV].left   = col_one ? s1_x_reg : hist_x2_reg;
        lanes[dse_pkg::LANE_PREV].right  = s1_past_last_reg ? s1_cur_b : s1_x_reg;

        // Last row, last column: right edge reflects onto the second-to-last column.
        lanes[dse_pkg::LANE_CUR].valid   = s1_last_row_reg && s1_last_col_reg;
        lanes[dse_pkg::LANE_CUR].row     = s1_row_reg;
        lanes[dse_pkg::LANE_CUR].col     = dse_pkg::COL_OUT_W'(s1_col_reg);
        lanes[dse_pkg::LANE_CUR].ctr     = s1_x_reg;
        lanes[dse_pkg::LANE_CUR].up      = s1_mid_a;
        lanes[dse_pkg::LANE_CUR].down    = s1_mid_a;
        lanes[dse_pkg::LANE_CUR].left    = hist_x1_reg;
        lanes[dse_pkg::LANE_CUR].right   = s1_cur_b;

        // burst ends on the highest slot in use; the grid ends on the last slot
        lanes[dse_pkg::LANE_UPPER].eob = lanes[dse_pkg::LANE_UPPER].valid
                                         && !lanes[dse_pkg::LANE_PREV].valid
                                         && !lanes[dse_pkg::LANE_CUR].valid;
        lanes[dse_pkg::LANE_PREV].eob  = lanes[dse_pkg::LANE_PREV].valid
                                         && !lanes[dse_pkg::LANE_CUR].valid;
        lanes[dse_pkg::LANE_CUR].eob   = lanes[dse_pkg::LANE_CUR].valid;
        lanes[dse_pkg::LANE_UPPER].eog = 1'b0;
        lanes[dse_pkg::LANE_PREV].eog  = 1'b0;
        lanes[dse_pkg::LANE_CUR].eog   = lanes[dse_pkg::LANE_CUR].valid;
    end

    dse_result_stage u_result (
        .clk          (clk),
        .rst_n        (rst_n),
        .lanes_valid  (s1_valid_reg),
        .lanes        (lanes),
        .coef_row_dir (cfg.coef_row_dir),
        .coef_col_dir (cfg.coef_col_dir),
        .advance      (advance),
        .results      (results)
    );

    // back-pressure only comes from an occupied sample register
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !samples.ready |-> s1_valid_reg)
        else $error("input stalled with an empty sample register");

    // line-store rotation stays on the three banks
    a_bank_range: assert property (@(posedge clk) disable iff (!rst_n)
        cur_bank_reg <= BANK_LAST)
        else $error("line-store rotation out of range");

    // end of a row rotates the stores, any other request steps the column
    a_row_rotates: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && last_col) |=> (cur_bank_reg != $past(cur_bank_reg)) && (col_cnt_reg == '0))
        else $error("row end did not rotate the line stores");

    a_col_steps: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && !last_col) |=> (col_cnt_reg == $past(col_cnt_reg) + CW'(1)))
        else $error("column counter did not advance");

endmodule

FILE: sim/tb_diffusion_stencil_euler_step_unit.sv
`timescale 1ns / 100ps
// Self-checking bench for the explicit Euler diffusion step over a raster grid.
// Depends on dse_pkg, dse_sample_if, dse_result_if and diffusion_stencil_euler_step_unit.
module tb_diffusion_stencil_euler_step_unit;

    localparam int LINE_DEPTH = 256;
    localparam int IDLE_PCT   = 34;
    localparam int HOLD_LEN   = 300;      // receiver hold-off, in cycles
    localparam int HOLD_STEP  = 200;      // results between hold-off starts
    localparam int LAST_HOLD  = 400;      // no hold-off is started beyond this result count
    localparam int REPORT_CAP = 30;       // keep the log short when the block is badly broken

    localparam logic signed [dse_pkg::SAMPLE_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [dse_pkg::SAMPLE_W-1:0] Q_MIN = 32'sh8000_0000;
    localparam logic [dse_pkg::COEF_W-1:0]          COEF_MAX = '1;

    // One updated grid point as it should leave the block
    typedef struct {
        logic signed [dse_pkg::SAMPLE_W-1:0] value;
        logic [dse_pkg::ROW_W-1:0]           row;
        logic [dse_pkg::COL_OUT_W-1:0]       col;
        logic                                eob;
        logic                                eog;
    } grid_point_t;

    logic clk;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [dse_pkg::PADDR_W-1:0] paddr;
    logic [dse_pkg::PDATA_W-1:0] pwdata;
    logic [dse_pkg::PDATA_W-1:0] prdata;
    logic pready;

    dse_sample_if smp ();
    dse_result_if res ();

    diffusion_stencil_euler_step_unit #(
        .MAX_COLS(LINE_DEPTH)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .samples (smp),
        .results (res)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // Shadow of the block: register copy, three row buffers and the raster
    // position of the next sample.
    // ------------------------------------------------------------------
    dse_pkg::cfg_t shadow_cfg;
    logic signed [dse_pkg::SAMPLE_W-1:0] line_prev [LINE_DEPTH];   // row r-1
    logic signed [dse_pkg::SAMPLE_W-1:0] line_mid  [LINE_DEPTH];   // row r
    logic signed [dse_pkg::SAMPLE_W-1:0] line_new  [LINE_DEPTH];   // row r+1, being filled
    int unsigned at_row;
    int unsigned at_col;

    logic signed [dse_pkg::SAMPLE_W-1:0] samples_to_send [$];
    grid_point_t                         pending_points  [$];

    int items_sent = 0;
    int results_seen;
    int errors = 0;
    int hold_left;
    int next_hold_at;

    // Both sides run without idling over a stretch of the random part
    wire tx_steady = (items_sent >= 360) && (items_sent < 440);
    wire rx_steady = (results_seen >= 160) && (results_seen < 230);

    // Out-of-range counts are clamped by the block
    function automatic int unsigned frame_rows();
        return (shadow_cfg.rows_in_use < 2) ? 2 : shadow_cfg.rows_in_use;
    endfunction

    function automatic int unsigned frame_cols();
        if (shadow_cfg.cols_in_use < 2)
            return 2;
        if (shadow_cfg.cols_in_use > LINE_DEPTH)
            return LINE_DEPTH;
        return shadow_cfg.cols_in_use;
    endfunction

    // Euler update of column j of the row held in ln, with reflected edges.
    // Products are exact in 64 bits; round half up, then saturate.
    function automatic logic signed [dse_pkg::SAMPLE_W-1:0] euler_update(
        input logic signed [dse_pkg::SAMPLE_W-1:0] ln [LINE_DEPTH],
        input int unsigned                         j,
        input int unsigned                         ncols,
        input logic signed [dse_pkg::SAMPLE_W-1:0] up,
        input logic signed [dse_pkg::SAMPLE_W-1:0] down
    );
        longint x;
        longint lf;
        longint rt;
        longint cr;
        longint cc;
        longint acc;
        longint v;
        x  = ln[j];
        lf = (j == 0) ? ln[1] : ln[j - 1];
        rt = (j + 1 >= ncols) ? ln[ncols - 2] : ln[j + 1];
        cr = shadow_cfg.coef_row_dir;
        cc = shadow_cfg.coef_col_dir;
        acc = cr * (up - 2 * x + down) + cc * (lf - 2 * x + rt);
        v = x + ((acc + 64'sd32768) >>> 16);
        if (v > 64'sd2147483647)
            v = 64'sd2147483647;
        if (v < -64'sd2147483648)
            v = -64'sd2147483648;
        return v[dse_pkg::SAMPLE_W-1:0];
    endfunction

    // Advance the shadow by one accepted sample and queue what it releases
    task automatic advance_stencil(input logic signed [dse_pkg::SAMPLE_W-1:0] x);
        int unsigned nrows;
        int unsigned ncols;
        int unsigned r;
        int unsigned c;
        bit last_row;
        bit last_col;
        grid_point_t burst [$];
        grid_point_t pt;
        nrows = frame_rows();
        ncols = frame_cols();
        r = at_row;
        c = at_col;
        // A counter past a lowered limit still counts as the last row or column
        last_row = (r + 1 >= nrows);
        last_col = (c + 1 >= ncols);
        line_new[c] = x;
        pt.eob = 1'b0;
        pt.eog = 1'b0;
        // Point one row above; on row 1 the top edge reflects onto row 1 itself
        if (r >= 1) begin
            pt.value = euler_update(line_mid, c, ncols, (r == 1) ? line_new[c] : line_prev[c],
                                    line_new[c]);
            pt.row = dse_pkg::ROW_W'(r - 1);
            pt.col = dse_pkg::COL_OUT_W'(c);
            burst.push_back(pt);
        end
        // Last row: bottom edge reflects onto the row above, so up and down coincide
        if (last_row) begin
            if (c >= 1) begin
                pt.value = euler_update(line_new, c - 1, ncols, line_mid[c - 1], line_mid[c - 1]);
                pt.row = dse_pkg::ROW_W'(r);
                pt.col = dse_pkg::COL_OUT_W'(c - 1);
                burst.push_back(pt);
            end
            if (last_col) begin
                pt.value = euler_update(line_new, c, ncols, line_mid[c], line_mid[c]);
                pt.row = dse_pkg::ROW_W'(r);
                pt.col = dse_pkg::COL_OUT_W'(c);
                pt.eog = 1'b1;
                burst.push_back(pt);
            end
        end
        if (burst.size() != 0)
            burst[burst.size() - 1].eob = 1'b1;
        foreach (burst[k])
            pending_points.push_back(burst[k]);
        if (last_col) begin
            at_col = 0;
            at_row = last_row ? 0 : r + 1;
            line_prev = line_mid;
            line_mid = line_new;
        end else begin
            at_col = c + 1;
        end
    endtask

    // ------------------------------------------------------------------
    // Sample driver: offer the next queued sample, hold it until taken.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            smp.valid <= 1'b0;
            smp.sample_value <= '0;
        end else begin
            if (smp.valid && smp.ready) begin
                advance_stencil(smp.sample_value);
                items_sent++;
            end
            if (!smp.valid || smp.ready) begin
                if (samples_to_send.size() != 0 && (tx_steady || $urandom_range(99) >= IDLE_PCT))
                begin
                    smp.valid <= 1'b1;
                    smp.sample_value <= samples_to_send.pop_front();
                end else begin
                    smp.valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver hold-off: at a few result counts, drop ready for a long
    // stretch while the driver keeps offering, so the block backs up.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            hold_left <= 0;
            next_hold_at <= 50;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (results_seen >= next_hold_at && next_hold_at <= LAST_HOLD) begin
            hold_left <= HOLD_LEN;
            next_hold_at <= next_hold_at + HOLD_STEP;
        end
    end

    function automatic void check_field(input string name,
                                        input logic [dse_pkg::SAMPLE_W-1:0] want,
                                        input logic [dse_pkg::SAMPLE_W-1:0] got);
        if (got !== want) begin
            errors++;
            if (errors <= REPORT_CAP)
                $error("%s: expected %0h, got %0h", name, want, got);
        end
    endfunction

    // ------------------------------------------------------------------
    // Result monitor: compare each accepted result with the oldest expected point.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n) begin
        grid_point_t want;
        if (!rst_n) begin
            res.ready <= 1'b0;
            results_seen <= 0;
        end else begin
            if (res.valid && res.ready) begin
                results_seen <= results_seen + 1;
                if (pending_points.size() == 0) begin
                    errors++;
                    if (errors <= REPORT_CAP)
                        $error("result with none expected: row %0d col %0d value %0h",
                               res.out_row, res.out_col, res.new_value);
                end else begin
                    want = pending_points.pop_front();
                    check_field("new_value", want.value, res.new_value);
                    check_field("out_row", want.row, res.out_row);
                    check_field("out_col", want.col, res.out_col);
                    check_field("end_of_burst", want.eob, res.end_of_burst);
                    check_field("end_of_grid", want.eog, res.end_of_grid);
                end
            end
            res.ready <= (hold_left == 0) && (rx_steady || $urandom_range(99) >= IDLE_PCT);
        end
    end

    // ------------------------------------------------------------------
    // Register access and stimulus helpers
    // ------------------------------------------------------------------

    // APB write: setup, then access; the register takes the value on the access edge
    task automatic write_reg(input logic [1:0] idx, input logic [dse_pkg::PDATA_W-1:0] value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        case (idx)
            dse_pkg::REG_ROWS:
                shadow_cfg.rows_in_use = value[dse_pkg::ROW_W-1:0];
            dse_pkg::REG_COLS:
                shadow_cfg.cols_in_use = value[dse_pkg::COLS_CFG_W-1:0];
            dse_pkg::REG_COEF_ROW:
                shadow_cfg.coef_row_dir = value[dse_pkg::COEF_W-1:0];
            dse_pkg::REG_COEF_COL:
                shadow_cfg.coef_col_dir = value[dse_pkg::COEF_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_grid(input int rows, input int cols, input int cr, input int cc);
        write_reg(dse_pkg::REG_ROWS, rows);
        write_reg(dse_pkg::REG_COLS, cols);
        write_reg(dse_pkg::REG_COEF_ROW, cr);
        write_reg(dse_pkg::REG_COEF_COL, cc);
        @(negedge clk);
    endtask

    // Wait until every queued sample is taken and every expected point has come,
    // then let the pipeline settle before touching the registers.
    task automatic wait_drained();
        do
            @(negedge clk);
        while (samples_to_send.size() != 0 || smp.valid || pending_points.size() != 0);
        repeat (8) @(posedge clk);
    endtask

    // Mostly values of a diffusing field, with extremes and raw words mixed in
    function automatic logic signed [dse_pkg::SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(9))
            0: return Q_MAX;
            1: return Q_MIN;
            2, 3: return $urandom;
            default: return int'($urandom_range(0, 1 << 20)) - (1 << 19);
        endcase
    endfunction

    function automatic int pick_coef();
        case ($urandom_range(9))
            0: return 0;
            1: return COEF_MAX;
            2: return $urandom_range(0, COEF_MAX);
            default: return $urandom_range(0, 18'h07FFF);
        endcase
    endfunction

    task automatic queue_frame(output int n);
        n = frame_rows() * frame_cols();
        repeat (n) samples_to_send.push_back(pick_sample());
    endtask

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin
        logic signed [dse_pkg::SAMPLE_W-1:0] corner [9];
        int random_items;
        int n;
        clk = 1'b0;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        at_row = 0;
        at_col = 0;
        shadow_cfg.rows_in_use = dse_pkg::ROWS_RESET;
        shadow_cfg.cols_in_use = dse_pkg::COLS_RESET;
        shadow_cfg.coef_row_dir = '0;
        shadow_cfg.coef_col_dir = '0;
        corner = '{Q_MAX, Q_MIN, Q_MIN, Q_MAX, 32'sd0, -32'sd1, 32'sd1,
                   32'sh0001_0000, 32'shAAAA_AAAA};

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Smallest grid, largest weights: a checkerboard of extremes saturates both ways
        set_grid(2, 2, COEF_MAX, COEF_MAX);
        for (int i = 0; i < 4; i++)
            samples_to_send.push_back(corner[i]);
        wait_drained();

        // Zero weights pass every sample through unchanged
        set_grid(3, 3, 0, 0);
        foreach (corner[i])
            samples_to_send.push_back(corner[i]);
        wait_drained();

        // Row and column counts below two act as two
        set_grid(1, 0, 32'h0001_0000, 32'h0000_8000);
        queue_frame(n);
        wait_drained();
        set_grid(0, 1, 32'h0000_4000, 32'h0002_0000);
        queue_frame(n);
        wait_drained();

        // Tallest frame, cut short: lower the row count after two rows so the
        // third row becomes the last one
        set_grid(16'hFFFF, 3, 32'h0000_4000, 32'h0000_2000);
        repeat (6) samples_to_send.push_back(pick_sample());
        wait_drained();
        write_reg(dse_pkg::REG_ROWS, 2);
        @(negedge clk);
        repeat (3) samples_to_send.push_back(pick_sample());
        wait_drained();

        // Widest frame with the column count clamped: a full first row and part of the
        // last one, then narrow the frame so the waiting column lies past the new last
        // column and closes the grid; the long hold-off lands in the partial row
        set_grid(2, 9'h1FF, pick_coef(), pick_coef());
        repeat (LINE_DEPTH + 40) samples_to_send.push_back(pick_sample());
        wait_drained();
        write_reg(dse_pkg::REG_COLS, 10);
        @(negedge clk);
        samples_to_send.push_back(pick_sample());
        wait_drained();

        // Random small frames under random settings
        random_items = 0;
        while (random_items < 150) begin
            set_grid(($urandom_range(99) < 80) ? $urandom_range(2, 5) : $urandom_range(0, 8),
                     ($urandom_range(99) < 80) ? $urandom_range(2, 10) : $urandom_range(0, 24),
                     pick_coef(), pick_coef());
            repeat ($urandom_range(1, 2)) begin
                queue_frame(n);
                random_items += n;
            end
            wait_drained();
        end

        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run
    initial begin
        #2_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule

FILE: sim.f
hdl/dse_pkg.sv
hdl/dse_sample_if.sv
hdl/dse_result_if.sv
hdl/dse_cfg_regs.sv
hdl/dse_line_bank.sv
hdl/dse_result_stage.sv
hdl/diffusion_stencil_euler_step_unit.sv
sim/tb_diffusion_stencil_euler_step_unit.sv
